// ----- src/mi3_pkg.sv -----
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types and constants for the 3x3 fixed-point matrix inverse block.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int ELEM_WIDTH_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int PORT_WIDTH      = 32;
    localparam int NUM_ELEMS       = 9;
    localparam int NUM_DET_TERMS   = 3;

    // cofactor k = e[A]*e[B] - e[C]*e[D], elements numbered row-major
    localparam int COF_A [NUM_ELEMS] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
    localparam int COF_B [NUM_ELEMS] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
    localparam int COF_C [NUM_ELEMS] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
    localparam int COF_D [NUM_ELEMS] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

    // determinant expands along row 0: a00*c0 + a01*c3 + a02*c6
    localparam int DET_COF [NUM_DET_TERMS] = '{0, 3, 6};

    typedef struct packed {
        logic signed [PORT_WIDTH-1:0] a00;
        logic signed [PORT_WIDTH-1:0] a01;
        logic signed [PORT_WIDTH-1:0] a02;
        logic signed [PORT_WIDTH-1:0] a10;
        logic signed [PORT_WIDTH-1:0] a11;
        logic signed [PORT_WIDTH-1:0] a12;
        logic signed [PORT_WIDTH-1:0] a20;
        logic signed [PORT_WIDTH-1:0] a21;
        logic signed [PORT_WIDTH-1:0] a22;
    } in_t;

    typedef struct packed {
        logic signed [PORT_WIDTH-1:0] b00;
        logic signed [PORT_WIDTH-1:0] b01;
        logic signed [PORT_WIDTH-1:0] b02;
        logic signed [PORT_WIDTH-1:0] b10;
        logic signed [PORT_WIDTH-1:0] b11;
        logic signed [PORT_WIDTH-1:0] b12;
        logic signed [PORT_WIDTH-1:0] b20;
        logic signed [PORT_WIDTH-1:0] b21;
        logic signed [PORT_WIDTH-1:0] b22;
        logic                         singular;
        logic                         overflow;
    } out_t;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ----- src/mi3_front.sv -----
// ----------------------------------------------------------------------------
// mi3_front
// Input pipeline: cofactors, determinant, and sign/magnitude split.
// ----------------------------------------------------------------------------
module mi3_front #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    output logic                                            in_ready,
    input  mi3_pkg::in_t                                    in_data,
    output logic                                            rec_valid,
    input  logic                                            rec_ready,
    output logic [mi3_pkg::NUM_ELEMS-1:0][2*ELEM_WIDTH-1:0] cmag,
    output logic [mi3_pkg::NUM_ELEMS-1:0]                   cneg,
    output logic [3*ELEM_WIDTH:0]                           dmag,
    output logic                                            dneg,
    output logic                                            singular
);
    import mi3_pkg::*;

    localparam int W    = ELEM_WIDTH;
    localparam int PW   = 2 * W;
    localparam int TW   = 3 * W;
    localparam int DETW = 3 * W + 2;
    localparam int DMW  = 3 * W + 1;
    localparam int NSTG = 7;

    logic [NSTG-1:0] v_reg;
    logic            en;

    logic [PORT_WIDTH-1:0] a [NUM_ELEMS];

    logic signed [W-1:0]    e_reg   [NUM_ELEMS];
    logic signed [PW-1:0]   p_reg   [2*NUM_ELEMS];
    logic signed [W-1:0]    ed2_reg [NUM_DET_TERMS];
    logic signed [W-1:0]    ed3_reg [NUM_DET_TERMS];
    logic signed [PW-1:0]   c_reg   [NUM_ELEMS];
    logic signed [PW-1:0]   c4_reg  [NUM_ELEMS];
    logic signed [PW-1:0]   c5_reg  [NUM_ELEMS];
    logic signed [PW-1:0]   ph_reg  [NUM_DET_TERMS];
    logic signed [PW:0]     pl_reg  [NUM_DET_TERMS];
    logic signed [TW-1:0]   pr_reg  [NUM_DET_TERMS];
    logic signed [DETW-1:0] det_reg;
    logic [PW-1:0]          cm6_reg [NUM_ELEMS];
    logic [NUM_ELEMS-1:0]   cn6_reg;
    logic [PW-1:0]          cm7_reg [NUM_ELEMS];
    logic [NUM_ELEMS-1:0]   cn7_reg;
    logic [DMW-1:0]         dmag_reg;
    logic                   dneg_reg;
    logic                   sing_reg;

    assign a[0] = in_data.a00;
    assign a[1] = in_data.a01;
    assign a[2] = in_data.a02;
    assign a[3] = in_data.a10;
    assign a[4] = in_data.a11;
    assign a[5] = in_data.a12;
    assign a[6] = in_data.a20;
    assign a[7] = in_data.a21;
    assign a[8] = in_data.a22;

    // whole pipe holds only when its last stage cannot hand off
    assign en        = !(v_reg[NSTG-1] && !rec_ready);
    assign in_ready  = en;
    assign rec_valid = v_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_ELEMS; i++)
            begin
                e_reg[i]     <= a[i][W-1:0];
                p_reg[2*i]   <= e_reg[COF_A[i]] * e_reg[COF_B[i]];
                p_reg[2*i+1] <= e_reg[COF_C[i]] * e_reg[COF_D[i]];
                c_reg[i]     <= p_reg[2*i] - p_reg[2*i+1];
                c4_reg[i]    <= c_reg[i];
                c5_reg[i]    <= c4_reg[i];
                cm6_reg[i]   <= c5_reg[i][PW-1] ? PW'(-c5_reg[i]) : PW'(c5_reg[i]);
                cn6_reg[i]   <= c5_reg[i][PW-1];
                cm7_reg[i]   <= cm6_reg[i];
            end
            for (int j = 0; j < NUM_DET_TERMS; j++)
            begin
                ed2_reg[j] <= e_reg[j];
                ed3_reg[j] <= ed2_reg[j];
                // split the wide cofactor so each multiply stays narrow
                ph_reg[j]  <= ed3_reg[j] * $signed(c_reg[DET_COF[j]][PW-1:W]);
                pl_reg[j]  <= ed3_reg[j] * $signed({1'b0, c_reg[DET_COF[j]][W-1:0]});
                pr_reg[j]  <= {ph_reg[j], {W{1'b0}}} + TW'(pl_reg[j]);
            end
            det_reg  <= DETW'(pr_reg[0]) + DETW'(pr_reg[1]) + DETW'(pr_reg[2]);
            cn7_reg  <= cn6_reg;
            dmag_reg <= det_reg[DETW-1] ? DMW'(-det_reg) : DMW'(det_reg);
            dneg_reg <= det_reg[DETW-1];
            sing_reg <= (det_reg == '0);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_ELEMS; i++)
        begin
            cmag[i] = cm7_reg[i];
        end
    end

    assign cneg     = cn7_reg;
    assign dmag     = dmag_reg;
    assign dneg     = dneg_reg;
    assign singular = sing_reg;

endmodule

// ----- src/mi3_queue.sv -----
// ----------------------------------------------------------------------------
// mi3_queue
// Short register queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module mi3_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mi3_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    import mi3_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/mi3_back.sv -----
// ----------------------------------------------------------------------------
// mi3_back
// Pipelined restoring dividers, one per element, with saturation.
// ----------------------------------------------------------------------------
module mi3_back #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    output logic                                            in_ready,
    input  logic [mi3_pkg::NUM_ELEMS-1:0][2*ELEM_WIDTH-1:0] cmag,
    input  logic [mi3_pkg::NUM_ELEMS-1:0]                   cneg,
    input  logic [3*ELEM_WIDTH:0]                           dmag,
    input  logic                                            dneg,
    input  logic                                            singular,
    output logic                                            out_valid,
    input  logic                                            out_ready,
    output mi3_pkg::out_t                                   out_data
);
    import mi3_pkg::*;

    localparam int W   = ELEM_WIDTH;
    localparam int QB  = W + 1;
    localparam int NW  = 2 * W + 2 * FRAC_BITS;
    localparam int HW  = NW - QB;
    localparam int RW  = 3 * W + 1;
    localparam int CW  = imax(HW, RW);
    localparam int NS  = QB + 1;
    localparam logic [QB-1:0] LIM    = QB'(1) << (W - 1);
    localparam logic [QB-1:0] LIM_M1 = LIM - 1'b1;

    logic [NS-1:0] v_reg;
    logic          en;

    logic [RW-1:0] rem_reg  [NS][NUM_ELEMS];
    logic [RW-1:0] rem_next [NS][NUM_ELEMS];
    logic [QB-1:0] num_reg  [NS][NUM_ELEMS];
    logic [QB-1:0] num_next [NS][NUM_ELEMS];
    logic [QB-1:0] quo_reg  [NS][NUM_ELEMS];
    logic [QB-1:0] quo_next [NS][NUM_ELEMS];
    logic          big_reg  [NS][NUM_ELEMS];
    logic          big_next [NS][NUM_ELEMS];
    logic          neg_reg  [NS][NUM_ELEMS];
    logic          neg_next [NS][NUM_ELEMS];
    logic [RW-1:0] dm_reg   [NS];
    logic [RW-1:0] dm_next  [NS];
    logic          sg_reg   [NS];
    logic          sg_next  [NS];

    logic                  out_valid_reg;
    out_t                  out_data_reg, out_data_next;
    logic [PORT_WIDTH-1:0] bo [NUM_ELEMS];
    logic                  ovf;

    assign en        = !(out_valid_reg && !out_ready);
    assign in_ready  = en;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        logic [NW-1:0] nv;
        logic [CW-1:0] hx;
        logic [RW:0]   t;
        logic [RW:0]   d;
        logic          ge;
        for (int i = 0; i < NUM_ELEMS; i++)
        begin
            nv = {cmag[i], {(2*FRAC_BITS){1'b0}}};
            hx = CW'(nv[NW-1:QB]);
            // quotient needs more than QB bits: certain saturation
            big_next[0][i] = (hx >= CW'(dmag));
            rem_next[0][i] = hx[RW-1:0];
            num_next[0][i] = nv[QB-1:0];
            quo_next[0][i] = '0;
            neg_next[0][i] = cneg[i] ^ dneg;
        end
        dm_next[0] = dmag;
        sg_next[0] = singular;
        for (int s = 1; s < NS; s++)
        begin
            for (int i = 0; i < NUM_ELEMS; i++)
            begin
                t  = {rem_reg[s-1][i], num_reg[s-1][i][QB-1]};
                d  = t - {1'b0, dm_reg[s-1]};
                ge = (t >= {1'b0, dm_reg[s-1]});
                rem_next[s][i] = ge ? d[RW-1:0] : t[RW-1:0];
                num_next[s][i] = num_reg[s-1][i] << 1;
                quo_next[s][i] = {quo_reg[s-1][i][QB-2:0], ge};
                big_next[s][i] = big_reg[s-1][i];
                neg_next[s][i] = neg_reg[s-1][i];
            end
            dm_next[s] = dm_reg[s-1];
            sg_next[s] = sg_reg[s-1];
        end
    end

    // sign, saturation and singular handling
    always_comb
    begin
        logic [QB-1:0]       q;
        logic [QB-1:0]       qn;
        logic                ov;
        logic signed [W-1:0] val;
        ovf = 1'b0;
        for (int i = 0; i < NUM_ELEMS; i++)
        begin
            q  = quo_reg[NS-1][i];
            qn = -q;
            if (neg_reg[NS-1][i])
            begin
                ov  = big_reg[NS-1][i] || (q > LIM);
                val = ov ? {1'b1, {(W-1){1'b0}}} : qn[W-1:0];
            end
            else
            begin
                ov  = big_reg[NS-1][i] || (q > LIM_M1);
                val = ov ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
            end
            bo[i] = sg_reg[NS-1] ? '0 : PORT_WIDTH'(val);
            ovf   = ovf | (ov && !sg_reg[NS-1]);
        end
        out_data_next = out_t'({bo[0], bo[1], bo[2], bo[3], bo[4], bo[5], bo[6], bo[7],
                                bo[8], sg_reg[NS-1], ovf});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[NS-2:0], in_valid};
            out_valid_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NS; s++)
            begin
                for (int i = 0; i < NUM_ELEMS; i++)
                begin
                    rem_reg[s][i] <= rem_next[s][i];
                    num_reg[s][i] <= num_next[s][i];
                    quo_reg[s][i] <= quo_next[s][i];
                    big_reg[s][i] <= big_next[s][i];
                    neg_reg[s][i] <= neg_next[s][i];
                end
                dm_reg[s] <= dm_next[s];
                sg_reg[s] <= sg_next[s];
            end
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ----- src/matrix_inverse_3x3_top.sv -----
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_top
// Inverse of a 3x3 fixed-point matrix per request, by adjugate over determinant.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one request: nine signed elements with
//   FRAC_BITS fraction bits, low ELEM_WIDTH bits used. out_valid/out_ready/
//   out_data return the nine inverse elements, saturated, plus singular and
//   overflow flags. One request can be taken every cycle while in_ready is high.
// Pipeline: 7 front stages (products, cofactors, determinant, magnitudes),
//   the queue, a setup stage, one divider stage per quotient bit, and an
//   output register for the saturated result.
// Throughput: one request per cycle while no stall holds the pipeline, set by the fully pipelined dividers.
// Stall: when a result waits with out_ready low the back pipeline holds; the queue between
//   front and back absorbs QUEUE_DEPTH requests, after which the front holds
//   and in_ready drops.
// Reset: rst_n clears all valid flags and queue pointers; no results pending.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_top #(
    parameter int ELEM_WIDTH  = mi3_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS   = mi3_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = mi3_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mi3_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output mi3_pkg::out_t out_data
);
    import mi3_pkg::*;

    localparam int CMW   = 2 * ELEM_WIDTH;
    localparam int DMW   = 3 * ELEM_WIDTH + 1;
    localparam int REC_W = NUM_ELEMS * CMW + NUM_ELEMS + DMW + 2;

    logic [NUM_ELEMS-1:0][CMW-1:0] f_cmag, b_cmag;
    logic [NUM_ELEMS-1:0]          f_cneg, b_cneg;
    logic [DMW-1:0]                f_dmag, b_dmag;
    logic                          f_dneg, b_dneg;
    logic                          f_sing, b_sing;
    logic                          f_valid, f_ready;
    logic                          b_valid, b_ready;
    logic [REC_W-1:0]              q_in, q_out;

    mi3_front #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .rec_valid (f_valid),
        .rec_ready (f_ready),
        .cmag      (f_cmag),
        .cneg      (f_cneg),
        .dmag      (f_dmag),
        .dneg      (f_dneg),
        .singular  (f_sing)
    );

    assign q_in = {f_cmag, f_cneg, f_dmag, f_dneg, f_sing};

    mi3_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (q_in),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (q_out)
    );

    assign {b_cmag, b_cneg, b_dmag, b_dneg, b_sing} = q_out;

    mi3_back #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid),
        .in_ready  (b_ready),
        .cmag      (b_cmag),
        .cneg      (b_cneg),
        .dmag      (b_dmag),
        .dneg      (b_dneg),
        .singular  (b_sing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- sim/matrix_inverse_3x3_top_test.sv -----
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_top_test
// Streams 3x3 Q16.16 matrices through the inverse block and checks each
// result against an exact adjugate-over-determinant prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class inverse_scoreboard;
    mi3_pkg::out_t pending_inverses[$];
    int            error_count;

    static function mi3_pkg::out_t invert(mi3_pkg::in_t m);
        mi3_pkg::out_t r;
        logic signed [63:0]  e[9];
        logic signed [127:0] cof[9];
        logic signed [127:0] det;
        logic signed [255:0] num, quo;
        logic signed [255:0] hi_lim, lo_lim;
        logic signed [31:0]  v[9];
        int                  i;
        e[0] = m.a00; e[1] = m.a01; e[2] = m.a02;
        e[3] = m.a10; e[4] = m.a11; e[5] = m.a12;
        e[6] = m.a20; e[7] = m.a21; e[8] = m.a22;
        cof[0] = e[4] * e[8] - e[7] * e[5];
        cof[1] = e[2] * e[7] - e[1] * e[8];
        cof[2] = e[1] * e[5] - e[2] * e[4];
        cof[3] = e[5] * e[6] - e[3] * e[8];
        cof[4] = e[0] * e[8] - e[2] * e[6];
        cof[5] = e[3] * e[2] - e[0] * e[5];
        cof[6] = e[3] * e[7] - e[6] * e[4];
        cof[7] = e[6] * e[1] - e[0] * e[7];
        cof[8] = e[0] * e[4] - e[3] * e[1];
        det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
        r = '0;
        if (det == 0)
        begin
            r.singular = 1'b1;
            return r;
        end
        hi_lim = 256'sd2147483647;
        lo_lim = -256'sd2147483648;
        for (i = 0; i < 9; i++)
        begin
            num = 256'(cof[i]) <<< 32;
            // signed division truncates toward zero
            quo = num / 256'(det);
            if (quo > hi_lim)
            begin
                v[i] = 32'h7fffffff;
                r.overflow = 1'b1;
            end
            else if (quo < lo_lim)
            begin
                v[i] = 32'h80000000;
                r.overflow = 1'b1;
            end
            else
                v[i] = quo[31:0];
        end
        r.b00 = v[0]; r.b01 = v[1]; r.b02 = v[2];
        r.b10 = v[3]; r.b11 = v[4]; r.b12 = v[5];
        r.b20 = v[6]; r.b21 = v[7]; r.b22 = v[8];
        return r;
    endfunction

    function void note_request(mi3_pkg::in_t m);
        pending_inverses.push_back(invert(m));
    endfunction

    function void check_result(mi3_pkg::out_t got);
        mi3_pkg::out_t want;
        if (pending_inverses.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, got);
            error_count++;
            return;
        end
        want = pending_inverses.pop_front();
        if (want !== got)
        begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            error_count++;
        end
    endfunction
endclass

module matrix_inverse_3x3_top_test;
    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    mi3_pkg::in_t  in_data = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    mi3_pkg::out_t out_data;

    inverse_scoreboard sb = new();
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    longint            cycle_count = 0;

    localparam longint CYCLE_LIMIT = 400000;
    localparam logic signed [31:0] ONE = 32'sh00010000;

    matrix_inverse_3x3_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver side: check and randomly stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(out_data);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(5))
            0: return $urandom;
            1: return {{12{1'b0}}, 20'($urandom)} - 32'h00080000;
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            3: return $urandom_range(1) ? ONE : -ONE;
            4: return 32'($signed($urandom_range(8))) - 4;
            default: return {{8{1'b0}}, 24'($urandom)} - 32'h00800000;
        endcase
    endfunction

    // valid drops only on idle cycles, so back to back requests keep it high
    task automatic send_request(mi3_pkg::in_t m);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= m;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(m);
    endtask

    task automatic send_matrix(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
                               logic [31:0] a3, logic [31:0] a4, logic [31:0] a5,
                               logic [31:0] a6, logic [31:0] a7, logic [31:0] a8);
        mi3_pkg::in_t m;
        m = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
        send_request(m);
    endtask

    task automatic send_random(int count);
        mi3_pkg::in_t m;
        int           k;
        for (k = 0; k < count; k++)
        begin
            m = '{rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                  rand_elem(), rand_elem(), rand_elem(), rand_elem()};
            // some singular ones: copy a row
            if ($urandom_range(9) == 0)
            begin
                m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
            end
            send_request(m);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // identity, negated identity, zero, singular, scaled, extremes
        send_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
        send_matrix(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE);
        send_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_matrix(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 5, 7, 9);
        send_matrix(2 * ONE, 0, 0, 0, 4 * ONE, 0, 0, 0, 32'hffff8000);
        send_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1);
        send_matrix(-1, 0, 0, 0, 1, 0, 0, 0, -1);
        send_matrix(32'h7fffffff, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 32'h7fffffff);
        send_matrix(32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000);
        send_matrix(32'h80000000, 32'h7fffffff, 1, 32'h7fffffff, 32'h80000000, 2,
                    3, 4, 32'h80000000);
        send_matrix(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                    32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_matrix(0, ONE, 0, 0, 0, ONE, ONE, 0, 0);
        send_matrix(3 * ONE, ONE, 0, ONE, 3 * ONE, ONE, 0, ONE, 3 * ONE);
        send_matrix(32'h55555555, 32'haaaaaaaa, 32'h12345678, 32'hedcba987,
                    32'h0f0f0f0f, 32'hf0f0f0f0, 32'h33333333, 32'hcccccccc, 32'h01010101);
        send_random(100);
        send_idle_pct = 79;
        send_random(110);
        send_idle_pct = 0;
        recv_stall_pct = 79;
        send_random(110);
        send_idle_pct = 37;
        recv_stall_pct = 37;
        send_random(110);
        in_valid <= 1'b0;
        recv_stall_pct = 0;
        while (sb.pending_inverses.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
